@@ rtl/cge_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cge_pkg;

    localparam int MAX_KEYS_DEF = 8;
    localparam int POS_W = 32;
    localparam int VAL_W = 16;
    localparam int DEN_W = 32;
    localparam int PROD_W = 48;
    localparam int ACCW = 49;
    localparam int QW = 16;
    localparam int RGB_W = 24;
    localparam int CNT_W = 4;
    localparam int NCH = 5;
    localparam int NSPAN = 2;
    localparam int CH_INT = 3;
    localparam int CH_ALPHA = 4;

    localparam logic [VAL_W-1:0] FULL_ALPHA = 16'hFFFF;
    localparam logic [RGB_W-1:0] UNIT_RGB = 24'h010000;
    localparam logic [31:0] RGB_ROUND = 32'd128;

    typedef enum logic [1:0] {
        FUNC_WR_COLOR = 2'd0,
        FUNC_WR_ALPHA = 2'd1,
        FUNC_EVAL     = 2'd2
    } func_t;

    typedef enum logic {
        CFG_COLOR_COUNT = 1'b0,
        CFG_ALPHA_COUNT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]              func;
        logic [2:0]              key_slot;
        logic signed [POS_W-1:0] position;
        logic [VAL_W-1:0]        key_red;
        logic [VAL_W-1:0]        key_green;
        logic [VAL_W-1:0]        key_blue;
        logic [VAL_W-1:0]        key_intensity;
        logic [VAL_W-1:0]        key_alpha;
    } in_item_t;

    typedef struct packed {
        logic [RGB_W-1:0] out_red;
        logic [RGB_W-1:0] out_green;
        logic [RGB_W-1:0] out_blue;
        logic [VAL_W-1:0] out_alpha;
    } out_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_lo;
        logic signed [POS_W-1:0] pos_hi;
        logic                    flat;
    } span_sel_t;

    typedef struct packed {
        logic signed [POS_W-1:0]        x;
        span_sel_t [NSPAN-1:0]          span;
        logic [NCH-1:0][VAL_W-1:0]      val_lo;
        logic [NCH-1:0][VAL_W-1:0]      val_hi;
        logic                           no_color;
    } sel_t;

    typedef struct packed {
        logic [NSPAN-1:0][DEN_W-1:0] den;
        logic [NCH-1:0][ACCW-1:0]    acc;
        logic                        no_color;
    } acc_t;

    typedef struct packed {
        logic [NCH-1:0][QW-1:0] quo;
        logic                   no_color;
    } quo_t;

    function automatic int span_of(input int ch);
        return (ch == CH_ALPHA) ? 1 : 0;
    endfunction

endpackage

`default_nettype wire

@@ rtl/color_gradient_evaluator_core.sv @@
// Colour and alpha gradient evaluator. Key writes (func 0 colour, func 1 alpha) and
// evaluations (func 2) share one item stream and take effect in order; func 3 items are
// dropped. An evaluation yields one result item, and a new item may be accepted every cycle
// while the output does not stall: two stages for key lookup, five for segment arithmetic
// and the interpolation products, sixteen for the restoring divider (one quotient bit per
// stage) and one for the intensity multiply that also serves as the output register.
// Stalls only back up the pipeline as far as its bubbles allow. Key counts must be written
// through the configuration port only while no item is in flight; the core does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module color_gradient_evaluator_core #(
    parameter int MAX_KEYS = cge_pkg::MAX_KEYS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  cge_pkg::in_item_t         req_item,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output cge_pkg::out_item_t        rsp_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [cge_pkg::CNT_W-1:0] cfg_data
);
    import cge_pkg::*;

    logic [CNT_W-1:0] color_count_reg;
    logic [CNT_W-1:0] alpha_count_reg;

    logic req_ready;
    logic sel_valid, sel_ready;
    sel_t sel_data;
    logic acc_valid, acc_ready;
    acc_t acc_data;
    logic quo_valid, quo_ready;
    quo_t quo_data;

    assign cfg_ready = 1'b1;
    assign req_stall = !req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_count_reg <= '0;
            alpha_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COLOR_COUNT: color_count_reg <= cfg_data;
                CFG_ALPHA_COUNT: alpha_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cge_keys #(
        .MAX_KEYS(MAX_KEYS)
    ) u_keys (
        .clk        (clk),
        .rst_n      (rst_n),
        .color_count(color_count_reg),
        .alpha_count(alpha_count_reg),
        .in_valid   (req_valid),
        .in_ready   (req_ready),
        .in_item    (req_item),
        .out_valid  (sel_valid),
        .out_ready  (sel_ready),
        .out_sel    (sel_data)
    );

    cge_span u_span (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sel_valid),
        .in_ready (sel_ready),
        .in_sel   (sel_data),
        .out_valid(acc_valid),
        .out_ready(acc_ready),
        .out_acc  (acc_data)
    );

    cge_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (acc_valid),
        .in_ready (acc_ready),
        .in_acc   (acc_data),
        .out_valid(quo_valid),
        .out_ready(quo_ready),
        .out_quo  (quo_data)
    );

    cge_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (quo_valid),
        .in_ready (quo_ready),
        .in_quo   (quo_data),
        .out_valid(rsp_valid),
        .out_ready(!rsp_stall),
        .out_item (rsp_item)
    );

`ifndef SYNTHESIS
    a_sel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sel_valid && !sel_ready |=> sel_valid && $stable(sel_data))
        else $error("lookup stage dropped or changed a stalled item");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid && !acc_ready |=> acc_valid && $stable(acc_data))
        else $error("interpolation stage dropped or changed a stalled item");

    a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_stall |-> !req_stall)
        else $error("input stalled although the output is free");
`endif

endmodule

`default_nettype wire

@@ rtl/cge_keys.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cge_keys #(
    parameter int MAX_KEYS = cge_pkg::MAX_KEYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [cge_pkg::CNT_W-1:0]       color_count,
    input  logic [cge_pkg::CNT_W-1:0]       alpha_count,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cge_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cge_pkg::sel_t                   out_sel
);
    import cge_pkg::*;

    localparam int IW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);

    logic signed [POS_W-1:0]    cpos_mem [MAX_KEYS];
    logic [CH_INT:0][VAL_W-1:0] cval_mem [MAX_KEYS];
    logic signed [POS_W-1:0]    apos_mem [MAX_KEYS];
    logic [VAL_W-1:0]           aval_mem [MAX_KEYS];

    logic     a_v_reg;
    in_item_t a_item_reg;
    logic     b_v_reg;
    sel_t     b_sel_reg;

    logic a_eval;
    logic a_go;
    logic b_ready;
    logic slot_ok;
    logic [IW-1:0] slot_idx;

    logic [NW-1:0]           cnt [NSPAN];
    logic signed [POS_W-1:0] pos_v [NSPAN][MAX_KEYS];
    logic [MAX_KEYS-1:0]     gt_v [NSPAN];
    logic [MAX_KEYS-1:0]     ge_v [NSPAN];
    logic [IW-1:0]           lo_idx [NSPAN];
    logic [IW-1:0]           hi_idx [NSPAN];
    logic                    span_flat [NSPAN];

    assign a_eval   = (a_item_reg.func == FUNC_EVAL);
    assign b_ready  = !b_v_reg || out_ready;
    assign a_go     = a_v_reg && (!a_eval || b_ready);
    assign in_ready = !a_v_reg || a_go;
    assign slot_ok  = (32'(a_item_reg.key_slot) < MAX_KEYS);
    assign slot_idx = IW'(a_item_reg.key_slot);

    assign cnt[0] = (32'(color_count) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(color_count);
    assign cnt[1] = (32'(alpha_count) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(alpha_count);

    // segment search, all keys compared at once
    always_comb
    begin
        logic [IW-1:0] f;
        logic [IW-1:0] i;
        logic [NW-1:0] last;
        logic [NW-1:0] lim;
        logic          found;
        pos_v[0] = cpos_mem;
        pos_v[1] = apos_mem;
        for (int s = 0; s < NSPAN; s++)
        begin
            for (int k = 0; k < MAX_KEYS; k++)
            begin
                gt_v[s][k] = pos_v[s][k] > a_item_reg.position;
                ge_v[s][k] = pos_v[s][k] >= a_item_reg.position;
            end
            last  = cnt[s] - NW'(1);
            lim   = cnt[s] - NW'(2);
            f     = IW'(last);
            found = 1'b0;
            for (int k = 0; k < MAX_KEYS; k++)
            begin
                if (!found && NW'(k) < cnt[s] && ge_v[s][k])
                begin
                    f     = IW'(k);
                    found = 1'b1;
                end
            end
            i = f;
            if (!(ge_v[s][f] && !gt_v[s][f]) && f != '0)
            begin
                i = f - IW'(1);
            end
            if (cnt[s] >= NW'(2) && NW'(i) > lim)
            begin
                i = IW'(lim);
            end
            if (cnt[s] == '0 || gt_v[s][0])
            begin
                lo_idx[s]    = '0;
                hi_idx[s]    = '0;
                span_flat[s] = 1'b1;
            end
            else if (!gt_v[s][IW'(last)])
            begin
                lo_idx[s]    = IW'(last);
                hi_idx[s]    = IW'(last);
                span_flat[s] = 1'b1;
            end
            else
            begin
                lo_idx[s]    = i;
                hi_idx[s]    = i + IW'(1);
                span_flat[s] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_v_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_v_reg <= a_v_reg && a_eval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            a_item_reg <= in_item;
        end
    end

    // key writes leave the input stage in order with evaluations
    always_ff @(posedge clk)
    begin
        if (a_go && slot_ok && a_item_reg.func == FUNC_WR_COLOR)
        begin
            cpos_mem[slot_idx] <= a_item_reg.position;
            cval_mem[slot_idx] <= {a_item_reg.key_intensity, a_item_reg.key_blue,
                                   a_item_reg.key_green, a_item_reg.key_red};
        end
        if (a_go && slot_ok && a_item_reg.func == FUNC_WR_ALPHA)
        begin
            apos_mem[slot_idx] <= a_item_reg.position;
            aval_mem[slot_idx] <= a_item_reg.key_alpha;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_sel_reg.x        <= a_item_reg.position;
            b_sel_reg.no_color <= (cnt[0] == '0);
            b_sel_reg.span[0].pos_lo <= cpos_mem[lo_idx[0]];
            b_sel_reg.span[0].pos_hi <= cpos_mem[hi_idx[0]];
            b_sel_reg.span[0].flat   <= span_flat[0];
            b_sel_reg.span[1].pos_lo <= apos_mem[lo_idx[1]];
            b_sel_reg.span[1].pos_hi <= apos_mem[hi_idx[1]];
            b_sel_reg.span[1].flat   <= span_flat[1];
            for (int ch = 0; ch <= CH_INT; ch++)
            begin
                b_sel_reg.val_lo[ch] <= cval_mem[lo_idx[0]][ch];
                b_sel_reg.val_hi[ch] <= cval_mem[hi_idx[0]][ch];
            end
            b_sel_reg.val_lo[CH_ALPHA] <= (cnt[1] == '0) ? FULL_ALPHA : aval_mem[lo_idx[1]];
            b_sel_reg.val_hi[CH_ALPHA] <= (cnt[1] == '0) ? FULL_ALPHA : aval_mem[hi_idx[1]];
        end
    end

    assign out_valid = b_v_reg;
    assign out_sel   = b_sel_reg;

endmodule

`default_nettype wire

@@ rtl/cge_span.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cge_span (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cge_pkg::sel_t in_sel,
    output logic          out_valid,
    input  logic          out_ready,
    output cge_pkg::acc_t out_acc
);
    import cge_pkg::*;

    localparam int NS = 5;

    typedef struct packed {
        logic [NSPAN-1:0][POS_W:0] w;
        logic [NSPAN-1:0][POS_W:0] d;
        logic [NSPAN-1:0]          flat;
        logic [NCH-1:0][VAL_W-1:0] val_lo;
        logic [NCH-1:0][VAL_W-1:0] val_hi;
        logic                      no_color;
    } diff_t;

    typedef struct packed {
        logic [NSPAN-1:0][DEN_W-1:0] den;
        logic [NSPAN-1:0][DEN_W-1:0] num;
        logic [NCH-1:0][VAL_W-1:0]   val_lo;
        logic [NCH-1:0][VAL_W-1:0]   val_hi;
        logic                        no_color;
    } frac_t;

    typedef struct packed {
        logic [NSPAN-1:0][DEN_W-1:0] den;
        logic [NSPAN-1:0][DEN_W-1:0] num;
        logic [NSPAN-1:0][DEN_W-1:0] wd;
        logic [NCH-1:0][VAL_W-1:0]   val_lo;
        logic [NCH-1:0][VAL_W-1:0]   val_hi;
        logic                        no_color;
    } wgt_t;

    typedef struct packed {
        logic [NSPAN-1:0][DEN_W-1:0] den;
        logic [NCH-1:0][PROD_W-1:0]  p_lo;
        logic [NCH-1:0][PROD_W-1:0]  p_hi;
        logic                        no_color;
    } prod_t;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    diff_t c_reg, c_next;
    frac_t d_reg, d_next;
    wgt_t  e_reg, e_next;
    prod_t f_reg, f_next;
    acc_t  g_reg, g_next;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // segment width and offset
    always_comb
    begin
        c_next.val_lo   = in_sel.val_lo;
        c_next.val_hi   = in_sel.val_hi;
        c_next.no_color = in_sel.no_color;
        for (int s = 0; s < NSPAN; s++)
        begin
            c_next.flat[s] = in_sel.span[s].flat;
            c_next.w[s] = (POS_W+1)'(in_sel.span[s].pos_hi) - (POS_W+1)'(in_sel.span[s].pos_lo);
            c_next.d[s] = (POS_W+1)'(in_sel.x) - (POS_W+1)'(in_sel.span[s].pos_lo);
        end
    end

    // flat segments divide by one
    always_comb
    begin
        logic flat2;
        d_next.val_lo   = c_reg.val_lo;
        d_next.val_hi   = c_reg.val_hi;
        d_next.no_color = c_reg.no_color;
        for (int s = 0; s < NSPAN; s++)
        begin
            flat2 = c_reg.flat[s] || ($signed(c_reg.w[s]) <= 0);
            if (flat2)
            begin
                d_next.den[s] = DEN_W'(1);
                d_next.num[s] = '0;
            end
            else
            begin
                d_next.den[s] = c_reg.w[s][DEN_W-1:0];
                if ($signed(c_reg.d[s]) < 0)
                begin
                    d_next.num[s] = '0;
                end
                else if ($signed(c_reg.d[s]) > $signed(c_reg.w[s]))
                begin
                    d_next.num[s] = c_reg.w[s][DEN_W-1:0];
                end
                else
                begin
                    d_next.num[s] = c_reg.d[s][DEN_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        e_next.den      = d_reg.den;
        e_next.num      = d_reg.num;
        e_next.val_lo   = d_reg.val_lo;
        e_next.val_hi   = d_reg.val_hi;
        e_next.no_color = d_reg.no_color;
        for (int s = 0; s < NSPAN; s++)
        begin
            e_next.wd[s] = d_reg.den[s] - d_reg.num[s];
        end
    end

    always_comb
    begin
        f_next.den      = e_reg.den;
        f_next.no_color = e_reg.no_color;
        for (int ch = 0; ch < NCH; ch++)
        begin
            f_next.p_lo[ch] = PROD_W'(e_reg.val_lo[ch]) * PROD_W'(e_reg.wd[span_of(ch)]);
            f_next.p_hi[ch] = PROD_W'(e_reg.val_hi[ch]) * PROD_W'(e_reg.num[span_of(ch)]);
        end
    end

    // rounded half up before the divide
    always_comb
    begin
        g_next.den      = f_reg.den;
        g_next.no_color = f_reg.no_color;
        for (int ch = 0; ch < NCH; ch++)
        begin
            g_next.acc[ch] = ACCW'(f_reg.p_lo[ch]) + ACCW'(f_reg.p_hi[ch])
                           + ACCW'(f_reg.den[span_of(ch)] >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            c_reg <= c_next;
        end
        if (rdy[1])
        begin
            d_reg <= d_next;
        end
        if (rdy[2])
        begin
            e_reg <= e_next;
        end
        if (rdy[3])
        begin
            f_reg <= f_next;
        end
        if (rdy[4])
        begin
            g_reg <= g_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_acc   = g_reg;

endmodule

`default_nettype wire

@@ rtl/cge_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cge_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cge_pkg::acc_t in_acc,
    output logic          out_valid,
    input  logic          out_ready,
    output cge_pkg::quo_t out_quo
);
    import cge_pkg::*;

    localparam int NS = QW;

    typedef struct packed {
        logic [NSPAN-1:0][DEN_W-1:0] den;
        logic [NCH-1:0][ACCW-1:0]    rem;
        logic [NCH-1:0][QW-1:0]      quo;
        logic                        no_color;
    } div_t;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    div_t          st_src [NS];
    div_t          st_next [NS];
    div_t          st_reg [NS];

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam int BIT = QW - 1 - s;

        if (s == 0)
        begin : g_first
            assign st_src[s] = '{den: in_acc.den, rem: in_acc.acc, quo: '0,
                                 no_color: in_acc.no_color};
        end
        else
        begin : g_next
            assign st_src[s] = st_reg[s-1];
        end

        always_comb
        begin
            logic [ACCW-1:0] dv;
            st_next[s] = st_src[s];
            for (int ch = 0; ch < NCH; ch++)
            begin
                dv = ACCW'(st_src[s].den[span_of(ch)]) << BIT;
                if (st_src[s].rem[ch] >= dv)
                begin
                    st_next[s].rem[ch]      = st_src[s].rem[ch] - dv;
                    st_next[s].quo[ch][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign in_ready         = rdy[0];
    assign out_valid        = v_reg[NS-1];
    assign out_quo.quo      = st_reg[NS-1].quo;
    assign out_quo.no_color = st_reg[NS-1].no_color;

endmodule

`default_nettype wire

@@ rtl/cge_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cge_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cge_pkg::quo_t      in_quo,
    output logic               out_valid,
    input  logic               out_ready,
    output cge_pkg::out_item_t out_item
);
    import cge_pkg::*;

    logic      v_reg;
    out_item_t item_reg;
    out_item_t item_next;
    logic [31:0] prod [CH_INT];

    assign in_ready = !v_reg || out_ready;

    // colour times intensity, rounded, q8.16
    always_comb
    begin
        for (int ch = 0; ch < CH_INT; ch++)
        begin
            prod[ch] = 32'(in_quo.quo[ch]) * 32'(in_quo.quo[CH_INT]) + RGB_ROUND;
        end
        item_next.out_red   = in_quo.no_color ? UNIT_RGB : prod[0][31:8];
        item_next.out_green = in_quo.no_color ? UNIT_RGB : prod[1][31:8];
        item_next.out_blue  = in_quo.no_color ? UNIT_RGB : prod[2][31:8];
        item_next.out_alpha = in_quo.quo[CH_ALPHA];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ test/color_gradient_scoreboard.sv @@
`timescale 1ns / 1ps

module color_gradient_scoreboard
    import cge_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  in_item_t            req_item,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  out_item_t           rsp_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [CNT_W-1:0]    cfg_data,
    output int                  errors,
    output int                  pending
);

    typedef logic signed [POS_W-1:0] pos_table_t [MAX_KEYS_DEF];

    pos_table_t       color_pos;
    pos_table_t       alpha_pos;
    logic [VAL_W-1:0] color_chan [MAX_KEYS_DEF][3];
    logic [VAL_W-1:0] color_gain [MAX_KEYS_DEF];
    logic [VAL_W-1:0] alpha_val [MAX_KEYS_DEF];
    logic [CNT_W-1:0] color_count;
    logic [CNT_W-1:0] alpha_count;
    out_item_t        gradient_q [$];

    function automatic void find_segment(input pos_table_t pos, input int n,
                                         input logic signed [POS_W-1:0] x,
                                         output int lo, output int hi,
                                         output longint unsigned num,
                                         output longint unsigned den);
        int     i;
        bit     found;
        longint w;
        longint d;
        num = 0;
        den = 1;
        lo = 0;
        hi = 0;
        found = 0;
        if (x < pos[0])
        begin
            lo = 0;
            hi = 0;
        end
        else if (pos[n-1] <= x)
        begin
            lo = n - 1;
            hi = n - 1;
        end
        else
        begin
            i = n - 1;
            for (int k = 0; k < n; k++)
            begin
                if (!found && pos[k] >= x)
                begin
                    i = k;
                    found = 1;
                end
            end
            if (pos[i] != x && i > 0)
                i--;
            if (i > n - 2)
                i = n - 2;
            w = longint'(pos[i+1]) - longint'(pos[i]);
            if (w <= 0)
            begin
                lo = i;
                hi = i;
            end
            else
            begin
                d = longint'(x) - longint'(pos[i]);
                if (d < 0)
                    d = 0;
                if (d > w)
                    d = w;
                lo = i;
                hi = i + 1;
                num = d;
                den = w;
            end
        end
    endfunction

    function automatic logic [31:0] lerp(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                                         input longint unsigned num,
                                         input longint unsigned den);
        longint unsigned acc;
        acc = longint'(a) * (den - num) + longint'(b) * num + den / 2;
        return 32'(acc / den);
    endfunction

    function automatic out_item_t sample_gradient(input logic signed [POS_W-1:0] x);
        out_item_t         r;
        int                nc;
        int                na;
        int                lo;
        int                hi;
        longint unsigned   num;
        longint unsigned   den;
        logic [31:0]       gain;
        logic [31:0]       chan [3];
        logic [63:0]       prod;
        nc = (color_count > MAX_KEYS_DEF) ? MAX_KEYS_DEF : color_count;
        na = (alpha_count > MAX_KEYS_DEF) ? MAX_KEYS_DEF : alpha_count;
        if (nc == 0)
        begin
            r.out_red = UNIT_RGB;
            r.out_green = UNIT_RGB;
            r.out_blue = UNIT_RGB;
        end
        else
        begin
            find_segment(color_pos, nc, x, lo, hi, num, den);
            gain = lerp(color_gain[lo], color_gain[hi], num, den);
            for (int c = 0; c < 3; c++)
            begin
                chan[c] = lerp(color_chan[lo][c], color_chan[hi][c], num, den);
            end
            prod = (64'(chan[0]) * gain + 128) >> 8;
            r.out_red = prod[RGB_W-1:0];
            prod = (64'(chan[1]) * gain + 128) >> 8;
            r.out_green = prod[RGB_W-1:0];
            prod = (64'(chan[2]) * gain + 128) >> 8;
            r.out_blue = prod[RGB_W-1:0];
        end
        if (na == 0)
            r.out_alpha = FULL_ALPHA;
        else
        begin
            find_segment(alpha_pos, na, x, lo, hi, num, den);
            r.out_alpha = 16'(lerp(alpha_val[lo], alpha_val[hi], num, den));
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            color_count = '0;
            alpha_count = '0;
            gradient_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_COLOR_COUNT)
                    color_count = cfg_data;
                else
                    alpha_count = cfg_data;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (gradient_q.size() == 0)
                begin
                    $error("result item with nothing expected");
                    errors++;
                end
                else
                begin
                    want = gradient_q.pop_front();
                    if (rsp_item.out_red !== want.out_red)
                    begin
                        $error("out_red: expected %0d, actual %0d", want.out_red, rsp_item.out_red);
                        errors++;
                    end
                    if (rsp_item.out_green !== want.out_green)
                    begin
                        $error("out_green: expected %0d, actual %0d",
                               want.out_green, rsp_item.out_green);
                        errors++;
                    end
                    if (rsp_item.out_blue !== want.out_blue)
                    begin
                        $error("out_blue: expected %0d, actual %0d",
                               want.out_blue, rsp_item.out_blue);
                        errors++;
                    end
                    if (rsp_item.out_alpha !== want.out_alpha)
                    begin
                        $error("out_alpha: expected %0d, actual %0d",
                               want.out_alpha, rsp_item.out_alpha);
                        errors++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                case (req_item.func)
                    FUNC_WR_COLOR:
                    begin
                        color_pos[req_item.key_slot] = req_item.position;
                        color_chan[req_item.key_slot][0] = req_item.key_red;
                        color_chan[req_item.key_slot][1] = req_item.key_green;
                        color_chan[req_item.key_slot][2] = req_item.key_blue;
                        color_gain[req_item.key_slot] = req_item.key_intensity;
                    end
                    FUNC_WR_ALPHA:
                    begin
                        alpha_pos[req_item.key_slot] = req_item.position;
                        alpha_val[req_item.key_slot] = req_item.key_alpha;
                    end
                    FUNC_EVAL:
                        gradient_q.push_back(sample_gradient(req_item.position));
                    default:
                    begin
                    end
                endcase
            end
        end
        pending = gradient_q.size();
    end

endmodule

@@ test/color_gradient_evaluator_core_tb.sv @@
`timescale 1ns / 1ps

module color_gradient_evaluator_core_tb;
    import cge_pkg::*;

    localparam int PIPE_DRAIN = 40;
    localparam int IDLE_LIMIT = 3000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    in_item_t         req_item = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    out_item_t        rsp_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    int               errors;
    int               pending;

    bit               sender_gaps = 1'b1;
    bit               receiver_gaps = 1'b1;
    bit               long_hold = 1'b0;
    int               quiet_cycles = 0;

    logic signed [POS_W-1:0] color_keys [MAX_KEYS_DEF];
    logic signed [POS_W-1:0] alpha_keys [MAX_KEYS_DEF];

    always #1 clk = ~clk;

    color_gradient_evaluator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    color_gradient_scoreboard chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side
    initial
    begin
        int n;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            n = receiver_gaps ? $urandom_range(0, 5) : 0;
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    task automatic send_item(input in_item_t it);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item <= it;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_count(input cfg_idx_t idx, input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t noise_fields();
        in_item_t it;
        it.func = FUNC_EVAL;
        it.key_slot = 3'($urandom);
        it.position = $urandom;
        it.key_red = pick_value();
        it.key_green = pick_value();
        it.key_blue = pick_value();
        it.key_intensity = pick_value();
        it.key_alpha = pick_value();
        return it;
    endfunction

    task automatic put_key(input func_t f, input int slot, input logic signed [POS_W-1:0] p);
        in_item_t it;
        it = noise_fields();
        it.func = f;
        it.key_slot = 3'(slot);
        it.position = p;
        if (f == FUNC_WR_COLOR)
            color_keys[slot] = p;
        else
            alpha_keys[slot] = p;
        send_item(it);
    endtask

    task automatic evaluate(input logic signed [POS_W-1:0] x);
        in_item_t it;
        it = noise_fields();
        it.position = x;
        send_item(it);
    endtask

    // sorted keys with repeats, or scattered ones
    task automatic load_table(input func_t f, input bit scattered);
        longint p;
        longint step;
        p = longint'($signed($urandom)) >>> $urandom_range(0, 20);
        for (int s = 0; s < MAX_KEYS_DEF; s++)
        begin
            if (scattered)
                p = longint'($signed($urandom));
            put_key(f, s, 32'(p));
            step = ($urandom_range(0, 4) == 0) ? 0
                 : $urandom_range(1, 1 << $urandom_range(2, 26));
            p = p + step;
            if (p > 64'sh7FFF_FFFF)
                p = 64'sh7FFF_FFFF;
        end
    endtask

    function automatic logic signed [POS_W-1:0] sample_point();
        int s;
        s = $urandom_range(0, MAX_KEYS_DEF - 2);
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return color_keys[s];
            2: return alpha_keys[s] + $signed(32'($urandom_range(0, 64))) - 32;
            3: return color_keys[s] + 32'($urandom_range(0, 1 << $urandom_range(0, 24)));
            4: return alpha_keys[s] + 32'($urandom_range(0, 1 << $urandom_range(0, 24)));
            5: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            default: return color_keys[s] - 1;
        endcase
    endfunction

    task automatic run_phase(input logic [CNT_W-1:0] nc, input logic [CNT_W-1:0] na,
                             input bit scattered, input int items);
        in_item_t it;
        int       r;
        drain();
        write_count(CFG_COLOR_COUNT, nc);
        write_count(CFG_ALPHA_COUNT, na);
        load_table(FUNC_WR_COLOR, scattered);
        load_table(FUNC_WR_ALPHA, scattered);
        for (int k = 0; k < items; k++)
        begin
            r = $urandom_range(0, 19);
            if (r < 2)
                put_key($urandom_range(0, 1) ? FUNC_WR_COLOR : FUNC_WR_ALPHA,
                        $urandom_range(0, MAX_KEYS_DEF - 1), sample_point());
            else if (r == 2)
            begin
                it = noise_fields();
                it.func = 2'd3;
                send_item(it);
            end
            else
                evaluate(sample_point());
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty tables, ignored function code
        evaluate(32'sh8000_0000);
        evaluate(32'sh7FFF_FFFF);
        begin
            in_item_t it;
            it = noise_fields();
            it.func = 2'd3;
            send_item(it);
        end
        evaluate('0);

        // extreme keys: full-range positions, zero and full-scale values
        for (int s = 0; s < MAX_KEYS_DEF; s++)
        begin
            in_item_t it;
            it = '0;
            it.func = FUNC_WR_COLOR;
            it.key_slot = 3'(s);
            it.position = (s == 0) ? 32'sh8000_0000 : (s == 7) ? 32'sh7FFF_FFFF
                        : 32'(s * 32'sh0001_0000);
            it.key_red = (s % 2) ? '1 : '0;
            it.key_green = (s % 3) ? '1 : '0;
            it.key_blue = 16'h8000;
            it.key_intensity = (s % 2) ? '1 : 16'h0100;
            color_keys[s] = it.position;
            send_item(it);
            it.func = FUNC_WR_ALPHA;
            it.key_alpha = (s % 2) ? '0 : '1;
            alpha_keys[s] = it.position;
            send_item(it);
        end
        drain();
        write_count(CFG_COLOR_COUNT, 4'd8);
        write_count(CFG_ALPHA_COUNT, 4'd8);
        evaluate(32'sh8000_0000);
        evaluate(32'sh7FFF_FFFF);
        evaluate(32'sh0002_0000);
        evaluate(32'sh0002_8000);
        evaluate(32'sh0001_0001);

        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        run_phase(4'd8, 4'd8, 1'b0, 90);
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        run_phase(4'd1, 4'd1, 1'b0, 60);
        // empty pipeline first, so the long hold lands on the next phase's items
        drain();
        long_hold = 1'b1;
        sender_gaps = 1'b0;
        run_phase(4'd2, 4'd3, 1'b0, 90);
        sender_gaps = 1'b1;
        run_phase(4'd15, 4'd0, 1'b0, 70);
        receiver_gaps = 1'b0;
        run_phase(4'd0, 4'd9, 1'b1, 70);
        receiver_gaps = 1'b1;
        run_phase(4'd5, 4'd6, 1'b0, 90);
        run_phase(4'd8, 4'd2, 1'b1, 60);
        run_phase(4'd3, 4'd12, 1'b0, 80);

        req_valid <= 1'b0;
        begin
            int waited;
            waited = 0;
            while (pending != 0 && waited < 20000)
            begin
                @(posedge clk);
                waited++;
            end
        end
        repeat (PIPE_DRAIN) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
